>>> rtl/pmd_pkg.sv
// Package: widths, constants, register codes and control types of the PID drive.
`timescale 1ns / 1ps
package pmd_pkg;

  localparam int SAMPLE_BITS = 12;
  localparam int SUM_BITS    = 32;

  localparam int CFG_W      = 14;
  localparam int CFG_DATA_W = (SAMPLE_BITS > CFG_W) ? SAMPLE_BITS : CFG_W;
  localparam int ERR_W      = SAMPLE_BITS + 1;
  localparam int DIFF_W     = ERR_W + 1;
  localparam int DUTY_W     = 16;
  localparam int DVSR_W     = 21;
  localparam int DIV_W      = SUM_BITS;
  localparam int DIV_CNT_W  = $clog2(DIV_W);
  localparam int QINT_W     = SUM_BITS - 5;
  localparam int BRK_W      = ((QINT_W > ERR_W) ? QINT_W : ERR_W) + 2;
  localparam int PROD_W     = BRK_W + CFG_W + 1;

  localparam int DUTY_MAX    = 65000;
  localparam int INT_SCALE   = 100;
  localparam int DELTA_SCALE = 10;

  localparam logic [SAMPLE_BITS-1:0] TARGET_RST = SAMPLE_BITS'((1 << SAMPLE_BITS) / 2);
  localparam logic [CFG_W-1:0]       GAIN_RST   = CFG_W'(50);
  localparam logic [CFG_W-1:0]       TI_RST     = CFG_W'(20);
  localparam logic [CFG_W-1:0]       TD_RST     = CFG_W'(10);

  typedef logic [SAMPLE_BITS-1:0] sample_t;
  typedef logic [DUTY_W-1:0]      duty_t;
  typedef logic [CFG_DATA_W-1:0]  cfg_data_t;

  typedef enum logic [1:0] {
    REG_TARGET = 2'd0,
    REG_GAIN   = 2'd1,
    REG_TI     = 2'd2,
    REG_TD     = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic load;      // take the sample, update sum and last error
    logic div_start; // launch the shared divider
    logic div_der;   // divider operands: 0 integral, 1 derivative
    logic cap_int;
    logic cap_der;
    logic add;
    logic mul;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic div_done;
  } status_t;

endpackage

>>> rtl/pmd_in_if.sv
// Input channel: one ADC sample item per handshake.
`timescale 1ns / 1ps
interface pmd_in_if;
  logic               valid;
  logic               ready;
  pmd_pkg::sample_t   adc_sample;

  modport source (output valid, output adc_sample, input ready);
  modport sink   (input valid, input adc_sample, output ready);
endinterface

>>> rtl/pmd_out_if.sv
// Output channel: one pair of PWM duties per handshake.
`timescale 1ns / 1ps
interface pmd_out_if;
  logic             valid;
  logic             ready;
  pmd_pkg::duty_t   duty_reverse;
  pmd_pkg::duty_t   duty_forward;

  modport source (output valid, output duty_reverse, output duty_forward, input ready);
  modport sink   (input valid, input duty_reverse, input duty_forward, output ready);
endinterface

>>> rtl/pmd_div.sv
// Shared restoring divider: unsigned, one quotient bit per cycle.
`timescale 1ns / 1ps
module pmd_div (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic [pmd_pkg::DIV_W-1:0]            dividend_i,
  input  logic [pmd_pkg::DVSR_W-1:0]           divisor_i,
  output logic                                 done_o,
  output logic [pmd_pkg::DIV_W-1:0]            quotient_o
);
  import pmd_pkg::*;

  logic                 busy_q, done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [DVSR_W-1:0]    rem_q, dvsr_q;
  logic [DIV_W-1:0]     quo_q;
  logic [DVSR_W:0]      shifted;
  logic [DVSR_W+1:0]    trial;
  logic                 ge;

  assign shifted = {rem_q, quo_q[DIV_W-1]};
  assign trial   = {1'b0, shifted} - {2'b00, dvsr_q};
  assign ge      = ~trial[DVSR_W+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == DIV_CNT_W'(DIV_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= '0;
      quo_q  <= dividend_i;
      dvsr_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[DIV_W-2:0], ge};
      rem_q <= ge ? trial[DVSR_W-1:0] : shifted[DVSR_W-1:0];
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

>>> rtl/pmd_datapath.sv
// Datapath: settings, loop state, divider operands, PID sum, gain product and duty clip.
`timescale 1ns / 1ps
module pmd_datapath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  pmd_pkg::cfg_idx_e    cfg_idx_i,
  input  pmd_pkg::cfg_data_t   cfg_data_i,
  input  pmd_pkg::sample_t     adc_sample_i,
  input  pmd_pkg::cmd_t        cmd_i,
  output pmd_pkg::status_t     status_o,
  output pmd_pkg::duty_t       duty_reverse_o,
  output pmd_pkg::duty_t       duty_forward_o
);
  import pmd_pkg::*;

  localparam logic signed [PROD_W-1:0] DutyLim = PROD_W'(DUTY_MAX);

  logic [SAMPLE_BITS-1:0]    target_q;
  logic [CFG_W-1:0]          gain_q, ti_q, td_q;

  logic signed [SUM_BITS-1:0] sum_q, sum_d;
  logic signed [ERR_W-1:0]    last_q, err_q, err_d;
  logic signed [DIFF_W-1:0]   diff_q;
  logic [DVSR_W-1:0]          divi_q, divd_q;
  logic signed [QINT_W-1:0]   qint_q;
  logic signed [DIFF_W-1:0]   qder_q;
  logic signed [BRK_W-1:0]    brk_q;
  logic signed [PROD_W-1:0]   prod_q;
  duty_t                      rev_q, fwd_q;

  logic signed [SUM_BITS:0]   sum_ext;
  logic [CFG_W-1:0]           ti_eff, td_eff;
  logic                       sum_neg, diff_neg;
  logic [DIV_W-1:0]           sum_mag;
  logic [DIFF_W-1:0]          diff_mag;
  logic [DIV_W-1:0]           dividend;
  logic [DVSR_W-1:0]          divisor;
  logic                       div_done;
  logic [DIV_W-1:0]           quotient;
  logic signed [PROD_W-1:0]   neg_prod;
  logic signed [CFG_W:0]      gain_s;

  // error and saturating sum for the incoming sample
  assign err_d   = $signed({1'b0, target_q}) - $signed({1'b0, adc_sample_i});
  assign sum_ext = (SUM_BITS+1)'(sum_q) + (SUM_BITS+1)'(err_d);
  always_comb begin
    if (sum_ext[SUM_BITS] != sum_ext[SUM_BITS-1]) begin
      sum_d = sum_ext[SUM_BITS] ? {1'b1, {(SUM_BITS-1){1'b0}}} : {1'b0, {(SUM_BITS-1){1'b1}}};
    end else begin
      sum_d = sum_ext[SUM_BITS-1:0];
    end
  end

  // a zero divisor acts as one
  assign ti_eff = (ti_q == '0) ? CFG_W'(1) : ti_q;
  assign td_eff = (td_q == '0) ? CFG_W'(1) : td_q;

  // nested truncating divisions fold into one by the product of divisors
  assign sum_neg  = sum_q[SUM_BITS-1];
  assign diff_neg = diff_q[DIFF_W-1];
  assign sum_mag  = sum_neg ? DIV_W'(-sum_q) : DIV_W'(sum_q);
  assign diff_mag = diff_neg ? DIFF_W'(-diff_q) : DIFF_W'(diff_q);
  assign dividend = cmd_i.div_der ? DIV_W'(diff_mag) : sum_mag;
  assign divisor  = cmd_i.div_der ? divd_q : divi_q;

  pmd_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dividend),
    .divisor_i  (divisor),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  assign status_o.div_done = div_done;
  assign gain_s   = $signed({1'b0, gain_q});
  assign neg_prod = -prod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= TARGET_RST;
      gain_q   <= GAIN_RST;
      ti_q     <= TI_RST;
      td_q     <= TD_RST;
      sum_q    <= '0;
      last_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_TARGET: target_q <= cfg_data_i[SAMPLE_BITS-1:0];
          REG_GAIN:   gain_q   <= cfg_data_i[CFG_W-1:0];
          REG_TI:     ti_q     <= cfg_data_i[CFG_W-1:0];
          REG_TD:     td_q     <= cfg_data_i[CFG_W-1:0];
          default:    ;
        endcase
      end
      if (cmd_i.load) begin
        sum_q  <= sum_d;
        last_q <= err_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      err_q  <= err_d;
      diff_q <= DIFF_W'(err_d) - DIFF_W'(last_q);
      divi_q <= DVSR_W'(ti_eff * INT_SCALE);
      divd_q <= DVSR_W'(td_eff * DELTA_SCALE);
    end
    if (cmd_i.cap_int) begin
      qint_q <= sum_neg ? -QINT_W'(quotient) : QINT_W'(quotient);
    end
    if (cmd_i.cap_der) begin
      qder_q <= diff_neg ? -DIFF_W'(quotient) : DIFF_W'(quotient);
    end
    if (cmd_i.add) begin
      brk_q <= BRK_W'(err_q) + BRK_W'(qint_q) + BRK_W'(qder_q);
    end
    if (cmd_i.mul) begin
      prod_q <= gain_s * brk_q;
    end
    if (cmd_i.out_load) begin
      if (prod_q < 0) begin
        rev_q <= (prod_q < -DutyLim) ? DUTY_W'(DUTY_MAX) : neg_prod[DUTY_W-1:0];
        fwd_q <= '0;
      end else begin
        rev_q <= '0;
        fwd_q <= (prod_q > DutyLim) ? DUTY_W'(DUTY_MAX) : prod_q[DUTY_W-1:0];
      end
    end
  end

  assign duty_reverse_o = rev_q;
  assign duty_forward_o = fwd_q;

endmodule

>>> rtl/pmd_ctrl.sv
// Controller: sequences one item through load, two divisions, sum, product and output.
`timescale 1ns / 1ps
module pmd_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  pmd_pkg::status_t   status_i,
  output pmd_pkg::cmd_t      cmd_o
);
  import pmd_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_STI, S_WI, S_STD, S_WD, S_ADD, S_MUL, S_OUT
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   out_free;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_free    = ~out_valid_q | out_ready_i;

  always_comb begin
    cmd_o           = '0;
    cmd_o.load      = in_valid_i & (state_q == S_IDLE);
    cmd_o.div_start = (state_q == S_STI) | (state_q == S_STD);
    cmd_o.div_der   = (state_q == S_STD) | (state_q == S_WD);
    cmd_o.cap_int   = (state_q == S_WI) & status_i.div_done;
    cmd_o.cap_der   = (state_q == S_WD) & status_i.div_done;
    cmd_o.add       = (state_q == S_ADD);
    cmd_o.mul       = (state_q == S_MUL);
    cmd_o.out_load  = (state_q == S_OUT) & out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      // load a new result as the held one leaves; otherwise drop it once taken
      if ((state_q == S_OUT) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: if (in_valid_i) state_q <= S_STI;
        S_STI:  state_q <= S_WI;
        S_WI:   if (status_i.div_done) state_q <= S_STD;
        S_STD:  state_q <= S_WD;
        S_WD:   if (status_i.div_done) state_q <= S_ADD;
        S_ADD:  state_q <= S_MUL;
        S_MUL:  state_q <= S_OUT;
        S_OUT: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/pid_motor_drive_split_pwm_unit.sv
// PID motor drive, top level: one ADC sample in, forward and reverse PWM duties out.
// Each sample passes through the integral and derivative divisions of the shared divider,
// then sum, gain product and output; a new sample is taken only once the duty item is loaded.
// A finished duty item waits in the output register while the next sample is taken.
// Reset (async, active low) sets target 2048, gain 50, integral 20, derivative 10,
// and clears the error sum, last error and output valid.
`timescale 1ns / 1ps
module pid_motor_drive_split_pwm_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  pmd_pkg::cfg_idx_e  cfg_idx_i,
  input  pmd_pkg::cfg_data_t cfg_data_i,
  pmd_in_if.sink             sample_i,
  pmd_out_if.source          result_o
);
  import pmd_pkg::*;

  cmd_t    cmd;
  status_t status;

  pmd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (sample_i.valid),
    .in_ready_o  (sample_i.ready),
    .out_valid_o (result_o.valid),
    .out_ready_i (result_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  pmd_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .adc_sample_i   (sample_i.adc_sample),
    .cmd_i          (cmd),
    .status_o       (status),
    .duty_reverse_o (result_o.duty_reverse),
    .duty_forward_o (result_o.duty_forward)
  );

endmodule

>>> rtl/pmd_checker.sv
// Checker on the top-level ports of the PID drive, bound to the top level.
`timescale 1ns / 1ps
module pmd_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_i,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input pmd_pkg::duty_t   duty_reverse_i,
  input pmd_pkg::duty_t   duty_forward_i
);
  import pmd_pkg::*;

  // never drive both directions
  a_one_direction: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (duty_reverse_i == '0 || duty_forward_i == '0))
    else $error("both duties nonzero");

  a_duty_clip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (duty_reverse_i <= DUTY_W'(DUTY_MAX) && duty_forward_i <= DUTY_W'(DUTY_MAX)))
    else $error("duty above clip level");

  // one item at a time: no second sample straight after an accept
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !in_ready_i)
    else $error("sample accepted while one is in work");

  a_hold_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(duty_reverse_i) && $stable(duty_forward_i)))
    else $error("stalled duty item changed");

endmodule

bind pid_motor_drive_split_pwm_unit pmd_checker u_pmd_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (sample_i.valid),
  .in_ready_i     (sample_i.ready),
  .out_valid_i    (result_o.valid),
  .out_ready_i    (result_o.ready),
  .duty_reverse_i (result_o.duty_reverse),
  .duty_forward_i (result_o.duty_forward)
);
